// File: rtl/ogs_pkg.sv
// Shared types and constants for the orbiter gravity step core.
// No dependencies.
package ogs_pkg;
  localparam int MAX_STARS_DEF = 16;
  localparam logic [15:0] DIV_RESET = 16'd300;
  localparam int QW = 4;

  typedef struct packed {
    logic signed [23:0] ox;
    logic signed [23:0] oy;
    logic signed [23:0] ovx;
    logic signed [23:0] ovy;
    logic [15:0]        omass;
    logic signed [23:0] sx;
    logic signed [23:0] sy;
    logic [15:0]        smass;
    logic [9:0]         srad;
    logic               present;
    logic               last;
  } item_t;

  // Integer square root, one result bit per call.
  typedef struct packed {
    logic [63:0] rem;
    logic [31:0] root;
  } sq_t;

  function automatic sq_t sqrt_step(sq_t s, logic [1:0] pair);
    logic [63:0] r;
    logic [63:0] t;
    sq_t o;
    r = {s.rem[61:0], pair};
    t = {30'd0, s.root, 2'b01};
    if (r >= t) begin
      o.rem = r - t;
      o.root = {s.root[30:0], 1'b1};
    end else begin
      o.rem = r;
      o.root = {s.root[30:0], 1'b0};
    end
    return o;
  endfunction
endpackage

// File: rtl/ogs_front.sv
// Input side of the gravity step core: takes words, pushes them into a small queue.
// Depends on ogs_pkg.
module ogs_front import ogs_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  q_valid,
  input  logic  q_pop,
  output item_t q_item
);
  localparam int AW = $clog2(QW);
  item_t mem [QW];
  logic [AW:0] wp_r, rp_r;
  logic push;

  assign in_ready = (wp_r - rp_r) != (AW + 1)'(QW);
  assign push = in_valid && in_ready;
  assign q_valid = wp_r != rp_r;
  assign q_item = mem[rp_r[AW-1:0]];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wp_r[AW-1:0]] <= in_item;
  end

  // pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (q_pop && q_valid) rp_r <= rp_r + 1'b1;
    end
  end

`ifndef SYNTHESIS
  a_no_over: assert property (@(posedge clk) disable iff (!rst_n)
    (wp_r - rp_r) <= (AW + 1)'(QW)) else $error("queue overfilled");
  a_pop_ok: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid) else $error("pop of empty queue");
  a_push_move: assert property (@(posedge clk) disable iff (!rst_n)
    push && !q_pop |=> wp_r != rp_r) else $error("push lost");
`endif
endmodule

// File: rtl/ogs_back.sv
// Back end: per-star force with iterative sqrt and dividers, end-of-run update and box scan.
// Depends on ogs_pkg.
module ogs_back import ogs_pkg::*; #(
  parameter int MAX_STARS = MAX_STARS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [15:0] divisor,
  input  logic        q_valid,
  output logic        q_pop,
  input  item_t       q_item,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [111:0] out_word
);
  localparam int BW = $clog2(MAX_STARS);
  localparam int CW = $clog2(MAX_STARS + 1);
  localparam int IW = (BW > 0) ? BW : 1;

  localparam logic [3:0] S_IDLE = 4'd0, S_SQ = 4'd1, S_DIV1 = 4'd2, S_DIV2 = 4'd3,
    S_MULX = 4'd4, S_DIVX = 4'd5, S_MULY = 4'd6, S_DIVY = 4'd7, S_ACC = 4'd8,
    S_FIN = 4'd9, S_SHSQ = 4'd10, S_SCAN = 4'd11, S_OUT = 4'd12;

  // counter mark: first cycle of the speed square root
  localparam logic [6:0] SH_LOAD = 7'd64;

  logic [3:0] st_r, st_nxt;
  item_t it_r;
  logic signed [24:0] dx_r, dy_r;
  logic [49:0] s_r;
  sq_t sq_r;
  logic [6:0] cnt_r;
  // shared restoring divider
  logic [63:0] dn_r, quo_r;
  logic [63:0] rm_r;
  logic [49:0] dv_r;
  logic [31:0] f_r;
  logic [31:0] cx_r;
  logic signed [31:0] fsx_r, fsy_r;
  logic [CW-1:0] bc_r;
  logic ovf_r;
  logic [57:0] box_mem [MAX_STARS];
  logic [57:0] box_rd_r;
  logic [CW-1:0] scan_r;
  logic rd_ok_r;
  logic cap_r;
  logic signed [23:0] vx_r, vy_r, px_r, py_r;
  logic [7:0] shade_r;
  logic ovo_r;
  logic ov_r;
  logic [111:0] ow_r;

  // divider step
  logic [64:0] rm_sh;
  logic [64:0] dvx;
  assign rm_sh = {rm_r, dn_r[63]};
  assign dvx = {15'd0, dv_r};

  function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                 logic signed [32:0] b);
    logic signed [33:0] s;
    s = 34'(a) + 34'(b);
    if (s > 34'sh7FFFFFFF) return 32'sh7FFFFFFF;
    if (s < -34'sh80000000) return 32'sh80000000;
    return s[31:0];
  endfunction

  function automatic logic signed [23:0] sat24(logic signed [33:0] v);
    if (v > 34'sd8388607) return 24'sh7FFFFF;
    if (v < -34'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  // squares at full width
  logic signed [47:0] vx2, vy2;
  assign vx2 = vx_r * vx_r;
  assign vy2 = vy_r * vy_r;
  logic [63:0] spd;
  assign spd = 64'(unsigned'(vx2)) + 64'(unsigned'(vy2));
  logic signed [24:0] dxn, dyn;
  assign dxn = 25'(q_item.ox) - 25'(q_item.sx);
  assign dyn = 25'(q_item.oy) - 25'(q_item.sy);
  logic signed [49:0] dx2, dy2;
  assign dx2 = dxn * dxn;
  assign dy2 = dyn * dyn;

  // box fields from registered read
  logic signed [23:0] bx, by;
  logic [9:0] br;
  logic signed [25:0] bxe, bye;
  assign bx = box_rd_r[57:34];
  assign by = box_rd_r[33:10];
  assign br = box_rd_r[9:0];
  assign bxe = 26'(bx) + 26'({br, 9'd0});
  assign bye = 26'(by) + 26'({br, 9'd0});

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign out_valid = ov_r;
  assign out_word = ow_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid) st_nxt = q_item.present ? S_SQ : S_FIN;
      S_SQ:   if (cnt_r == 7'd0) st_nxt = (s_r == '0) ? S_ACC : S_DIV1;
      S_DIV1, S_DIV2, S_DIVX, S_DIVY: if (cnt_r == 7'd0) st_nxt = st_r + 4'd1;
      S_MULX, S_MULY: st_nxt = st_r + 4'd1;
      S_ACC:  st_nxt = it_r.last ? S_FIN : S_IDLE;
      S_FIN:  st_nxt = S_SHSQ;
      S_SHSQ: if (cnt_r == 7'd0) st_nxt = S_SCAN;
      S_SCAN: if (scan_r == bc_r && !rd_ok_r) st_nxt = S_OUT;
      S_OUT:  if (!ov_r) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  // box write and registered read
  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && q_valid && q_item.present && bc_r < CW'(MAX_STARS))
      box_mem[IW'(bc_r)] <= {q_item.sx, q_item.sy, q_item.srad};
    box_rd_r <= box_mem[IW'(scan_r)];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      fsx_r <= '0;
      fsy_r <= '0;
      bc_r <= '0;
      ovf_r <= 1'b0;
      ov_r <= 1'b0;
      cnt_r <= '0;
      scan_r <= '0;
      rd_ok_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (ov_r && out_ready) ov_r <= 1'b0;
      unique case (st_r)
        S_IDLE: if (q_valid) begin
          it_r <= q_item;
          dx_r <= dxn;
          dy_r <= dyn;
          s_r <= unsigned'(dx2) + unsigned'(dy2);
          sq_r <= '0;
          // a word with no star goes straight to the end-of-run update
          cnt_r <= q_item.present ? 7'd24 : SH_LOAD;
          if (q_item.present) begin
            if (bc_r < CW'(MAX_STARS)) bc_r <= bc_r + 1'b1;
            else ovf_r <= 1'b1;
          end
        end
        S_SQ: begin
          sq_r <= sqrt_step(sq_r, s_r[49:48]);
          // 25 rotations by two bits bring s_r back to its starting value
          s_r <= {s_r[47:0], s_r[49:48]};
          if (cnt_r == 7'd0) begin
            dn_r <= {8'd0, 32'(it_r.omass) * 32'(it_r.smass), 24'd0};
            rm_r <= '0;
            dv_r <= {s_r[47:0], s_r[49:48]};
            cnt_r <= 7'd63;
            // coincident positions: this star adds no force
            if (s_r == '0) begin
              cx_r <= '0;
              quo_r <= '0;
            end
          end else cnt_r <= cnt_r - 1'b1;
        end
        S_DIV1, S_DIV2, S_DIVX, S_DIVY: begin
          quo_r <= {quo_r[62:0], rm_sh >= dvx};
          if (st_r == S_DIV1 && cnt_r == 7'd0) begin
            dn_r <= {quo_r[62:0], rm_sh >= dvx};
            rm_r <= '0;
            dv_r <= 50'(divisor == 16'd0 ? 16'd1 : divisor);
            cnt_r <= 7'd63;
          end else begin
            rm_r <= (rm_sh >= dvx) ? 64'(rm_sh - dvx) : rm_sh[63:0];
            dn_r <= {dn_r[62:0], 1'b0};
            cnt_r <= cnt_r - 1'b1;
          end
        end
        S_MULX, S_MULY: begin
          rm_r <= '0;
          cnt_r <= 7'd63;
          dv_r <= 50'(sq_r.root);
          if (st_r == S_MULX) begin
            f_r <= (quo_r > 64'h7FFFFFFF) ? 32'h7FFFFFFF : quo_r[31:0];
            dn_r <= 64'(56'(((quo_r > 64'h7FFFFFFF) ? 32'h7FFFFFFF : quo_r[31:0]))
                      * 56'(dx_r[24] ? -dx_r : dx_r));
          end else begin
            cx_r <= (quo_r > 64'hFFFFFFFF) ? 32'hFFFFFFFF : quo_r[31:0];
            dn_r <= 64'(56'(f_r) * 56'(dy_r[24] ? -dy_r : dy_r));
          end
        end
        S_ACC: begin
          fsx_r <= sat_add(fsx_r, dx_r[24] ? -33'(cx_r) : 33'(cx_r));
          fsy_r <= sat_add(fsy_r, dy_r[24] ? -33'(quo_r[31:0]) : 33'(quo_r[31:0]));
          if (it_r.last) cnt_r <= SH_LOAD;
        end
        S_FIN: begin
          vx_r <= sat24(34'(it_r.ovx) - 34'(fsx_r));
          vy_r <= sat24(34'(it_r.ovy) - 34'(fsy_r));
        end
        S_SHSQ: begin
          if (cnt_r == SH_LOAD) begin
            px_r <= sat24(34'(it_r.ox) + 34'(vx_r));
            py_r <= sat24(34'(it_r.oy) + 34'(vy_r));
            dn_r <= spd * 64'd25;
            sq_r <= '0;
            cnt_r <= 7'd31;
          end else begin
            sq_r <= sqrt_step(sq_r, dn_r[63:62]);
            dn_r <= {dn_r[61:0], 2'b00};
            cnt_r <= cnt_r - 1'b1;
            if (cnt_r == 7'd0) begin
              scan_r <= '0;
              rd_ok_r <= 1'b0;
              cap_r <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          if (rd_ok_r &&
              px_r >= bx && 26'(px_r) < bxe && py_r >= by && 26'(py_r) < bye)
            cap_r <= 1'b1;
          rd_ok_r <= scan_r != bc_r;
          if (scan_r != bc_r) scan_r <= scan_r + 1'b1;
          shade_r <= (sq_r.root[31:8] > 24'd255) ? 8'd255 : sq_r.root[15:8];
          ovo_r <= ovf_r;
        end
        S_OUT: if (!ov_r) begin
          // result register stays fixed while the next run is worked on
          ov_r <= 1'b1;
          ow_r <= {6'd0, ovo_r, cap_r, shade_r, vy_r, vx_r, py_r, px_r};
          fsx_r <= '0;
          fsy_r <= '0;
          bc_r <= '0;
          ovf_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    bc_r <= CW'(MAX_STARS)) else $error("box count past depth");
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> st_r == S_IDLE) else $error("pop while busy");
`endif
endmodule

// File: rtl/orbiter_gravity_step_core.sv
// Orbiter gravity step: one star word at a time, force accumulated into running sums;
// the run's last word yields one result. Each star takes a 25-step bit-serial
// square root and four 64-step restoring divisions that share one divider; the final
// update scans the stored boxes. A four-word queue decouples input from
// the compute engine, and a held result register lets the next run start while it waits.
// Depends on ogs_pkg, ogs_front, ogs_back.
module orbiter_gravity_step_core import ogs_pkg::*; #(
  parameter int MAX_STARS = MAX_STARS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         cfg_we,
  input  logic [15:0]  cfg_wdata,
  input  logic         in_tvalid,
  output logic         in_tready,
  // orbiter_x, orbiter_y, orbiter_vx, orbiter_vy, orbiter_mass, star_x, star_y,
  // star_mass, star_radius, star_present, pad
  input  logic [191:0] in_tdata,
  input  logic         in_tlast, // last_star
  output logic         out_tvalid,
  input  logic         out_tready,
  // new_x, new_y, new_vx, new_vy, speed_shade, captured, boxes_overflowed, pad
  output logic [111:0] out_tdata
);
  logic [15:0] div_r;
  item_t in_item, q_item;
  logic q_valid, q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) div_r <= DIV_RESET;
    else if (cfg_we) div_r <= cfg_wdata;
  end

  assign in_item = '{ox: in_tdata[23:0], oy: in_tdata[47:24], ovx: in_tdata[71:48],
    ovy: in_tdata[95:72], omass: in_tdata[111:96], sx: in_tdata[135:112],
    sy: in_tdata[159:136], smass: in_tdata[175:160], srad: in_tdata[185:176],
    present: in_tdata[186], last: in_tlast};

  ogs_front u_front (.clk, .rst_n, .in_valid(in_tvalid), .in_ready(in_tready),
    .in_item, .q_valid, .q_pop, .q_item);

  ogs_back #(.MAX_STARS(MAX_STARS)) u_back (.clk, .rst_n, .divisor(div_r), .q_valid,
    .q_pop, .q_item, .out_valid(out_tvalid), .out_ready(out_tready), .out_word(out_tdata));
endmodule
